/* hdl/tmau_pkg.sv */
// Package for the transform matrix accumulator unit.
// Holds the input and result word types, command codes and Q16.16 constants.
// No dependencies.
package tmau_pkg;

  localparam int DIM = 4;
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [1:0] row_t;
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_APPLY   = 2'd1;
  localparam cmd_t CMD_RESTORE = 2'd2;
  localparam cmd_t CMD_READ    = 2'd3;

  localparam row_t LAST_ROW = 2'd3;

  localparam elem_t Q_ONE  = 32'sh0001_0000;
  localparam elem_t Q_ZERO = 32'sh0000_0000;
  localparam elem_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam elem_t Q_MIN  = -32'sh7FFF_FFFF - 32'sh1;

  typedef struct packed {
    cmd_t  cmd;
    row_t  row;
    elem_t elem_0;
    elem_t elem_1;
    elem_t elem_2;
    elem_t elem_3;
  } in_word_t;

  typedef struct packed {
    row_t  out_row;
    elem_t acc_0;
    elem_t acc_1;
    elem_t acc_2;
    elem_t acc_3;
    logic  product_done;
    logic  saturated;
  } out_word_t;

endpackage

/* hdl/transform_matrix_accumulator_unit.sv */
// Latency: load, restore, read and apply of rows 0 to 2 return their word one cycle after
// start and keep busy low, so one such word is taken every cycle.
// Apply of row 3 holds busy for 19 cycles and returns its word 20 cycles after start:
// four multipliers produce one product element a cycle over 16 cycles, plus 3 pipeline cycles.
// Reset: both matrices become the identity; pending multiplier rows are undefined until written.
// The result is shown for one cycle with done high; the receiver cannot stall it.
module transform_matrix_accumulator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tmau_pkg::in_word_t item,
  output logic               done,
  output tmau_pkg::out_word_t result
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  state_t state;
  logic [4:0] cnt;
  logic v1, v2;
  logic clip;
  tmau_pkg::row_t prow;

  tmau_pkg::elem_t base_m [tmau_pkg::DIM][tmau_pkg::DIM];
  tmau_pkg::elem_t acc_m  [tmau_pkg::DIM][tmau_pkg::DIM];
  // Rows 0 to 2 are the pending multiplier rows, row 3 holds the carried row during a product.
  // The ring rotates once per issued element and is back in place after all sixteen.
  tmau_pkg::elem_t mult   [tmau_pkg::DIM][tmau_pkg::DIM];
  tmau_pkg::elem_t prodbuf [tmau_pkg::DIM*tmau_pkg::DIM];

  logic signed [2*tmau_pkg::ELEM_W-1:0] p [tmau_pkg::DIM];
  logic signed [2*tmau_pkg::ELEM_W:0]   s01, s23;

  logic signed [2*tmau_pkg::ELEM_W+1:0] sum_all;
  logic signed [2*tmau_pkg::ELEM_W+1-tmau_pkg::FRAC_W:0] shifted;
  tmau_pkg::elem_t sat_val;
  logic sat_hit;

  tmau_pkg::elem_t in_elems [tmau_pkg::DIM];
  tmau_pkg::elem_t imm_row  [tmau_pkg::DIM];
  logic accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_elems[0] = item.elem_0;
  assign in_elems[1] = item.elem_1;
  assign in_elems[2] = item.elem_2;
  assign in_elems[3] = item.elem_3;

  // Row returned by a command that finishes at once, as it reads after the update.
  always_comb begin
    for (int j = 0; j < tmau_pkg::DIM; j++) begin
      unique case (item.cmd)
        tmau_pkg::CMD_LOAD:    imm_row[j] = in_elems[j];
        tmau_pkg::CMD_RESTORE: imm_row[j] = base_m[item.row][j];
        default:               imm_row[j] = acc_m[item.row][j];
      endcase
    end
  end

  // Final stage: exact sum, floor shift by the fraction width, then saturation.
  always_comb begin
    sum_all = 66'(s01) + 66'(s23);
    shifted = sum_all[2*tmau_pkg::ELEM_W+1:tmau_pkg::FRAC_W];
    sat_hit = !((&shifted[$high(shifted):tmau_pkg::ELEM_W-1]) ||
                !(|shifted[$high(shifted):tmau_pkg::ELEM_W-1]));
    if (!sat_hit) begin
      sat_val = shifted[tmau_pkg::ELEM_W-1:0];
    end else if (shifted[$high(shifted)]) begin
      sat_val = tmau_pkg::Q_MIN;
    end else begin
      sat_val = tmau_pkg::Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      clip  <= 1'b0;
      done  <= 1'b0;
      for (int i = 0; i < tmau_pkg::DIM; i++) begin
        for (int k = 0; k < tmau_pkg::DIM; k++) begin
          base_m[i][k] <= (i == k) ? tmau_pkg::Q_ONE : tmau_pkg::Q_ZERO;
          acc_m[i][k]  <= (i == k) ? tmau_pkg::Q_ONE : tmau_pkg::Q_ZERO;
        end
      end
    end else begin
      done <= 1'b0;
      v1   <= (state == ST_RUN) && !cnt[4];
      v2   <= v1;

      if (v1) begin
        s01 <= 65'(p[0]) + 65'(p[1]);
        s23 <= 65'(p[2]) + 65'(p[3]);
      end
      if (v2) begin
        for (int n = 0; n < tmau_pkg::DIM*tmau_pkg::DIM - 1; n++) begin
          prodbuf[n] <= prodbuf[n+1];
        end
        prodbuf[tmau_pkg::DIM*tmau_pkg::DIM-1] <= sat_val;
        clip <= clip | sat_hit;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result.out_row      <= item.row;
            result.acc_0        <= imm_row[0];
            result.acc_1        <= imm_row[1];
            result.acc_2        <= imm_row[2];
            result.acc_3        <= imm_row[3];
            result.product_done <= 1'b0;
            result.saturated    <= 1'b0;
            unique case (item.cmd)
              tmau_pkg::CMD_LOAD: begin
                for (int j = 0; j < tmau_pkg::DIM; j++) begin
                  base_m[item.row][j] <= in_elems[j];
                  acc_m[item.row][j]  <= in_elems[j];
                end
                done <= 1'b1;
              end
              tmau_pkg::CMD_APPLY: begin
                for (int j = 0; j < tmau_pkg::DIM; j++) begin
                  mult[item.row][j] <= in_elems[j];
                end
                if (item.row == tmau_pkg::LAST_ROW) begin
                  state <= ST_RUN;
                  cnt   <= '0;
                  clip  <= 1'b0;
                  prow  <= item.row;
                end else begin
                  done <= 1'b1;
                end
              end
              tmau_pkg::CMD_RESTORE: begin
                acc_m <= base_m;
                done  <= 1'b1;
              end
              tmau_pkg::CMD_READ: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        ST_RUN: begin
          // Issue element (row i, column k) with i = cnt[1:0], k = cnt[3:2]; the multiplier
          // ring puts row i at slot 0 and the column rotation puts column k at slot 0.
          if (!cnt[4]) begin
            for (int j = 0; j < tmau_pkg::DIM; j++) begin
              p[j] <= mult[0][j] * acc_m[j][0];
            end
            for (int r = 0; r < tmau_pkg::DIM; r++) begin
              mult[r] <= mult[2'(r + 1)];
            end
            if (cnt[1:0] == 2'd3) begin
              for (int r = 0; r < tmau_pkg::DIM; r++) begin
                for (int c = 0; c < tmau_pkg::DIM; c++) begin
                  acc_m[r][c] <= acc_m[r][2'(c + 1)];
                end
              end
            end
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd17) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // The buffer holds the product column by column.
          for (int i = 0; i < tmau_pkg::DIM; i++) begin
            for (int k = 0; k < tmau_pkg::DIM; k++) begin
              acc_m[i][k] <= prodbuf[4'(k*tmau_pkg::DIM + i)];
            end
          end
          result.out_row      <= prow;
          result.acc_0        <= prodbuf[{2'd0, prow}];
          result.acc_1        <= prodbuf[{2'd1, prow}];
          result.acc_2        <= prodbuf[{2'd2, prow}];
          result.acc_3        <= prodbuf[{2'd3, prow}];
          result.product_done <= 1'b1;
          result.saturated    <= clip;
          done  <= 1'b1;
          state <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* test/tmau_checker.sv */
// Checker for the transform matrix accumulator unit: predicts every result word
// from the accepted input words and compares it field by field with the DUT.
// Depends on tmau_pkg for the word types, command codes and Q16.16 constants.
module tmau_checker
  import tmau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  item,
  input  logic      done,
  input  out_word_t result,
  output int        mismatch_count,
  output int        words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

  elem_t     base_rows [DIM][DIM];
  elem_t     accum_rows [DIM][DIM];
  elem_t     multiplier_rows [DIM][DIM];
  out_word_t expected_rows [$];

  // Updates the predicted matrices for one word and returns the row it reports.
  function automatic out_word_t transform_step(in_word_t w);
    elem_t              carried [DIM];
    elem_t              prod [DIM][DIM];
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [65:0] sum;
    logic               clipped;
    out_word_t          o;
    int                 i;
    int                 j;
    int                 k;
    clipped = 1'b0;
    carried = '{w.elem_0, w.elem_1, w.elem_2, w.elem_3};
    case (w.cmd)
      CMD_LOAD: begin
        base_rows[w.row] = carried;
        accum_rows[w.row] = carried;
      end
      CMD_APPLY: begin
        // Rows 0 to 2 stay collected after a product; row 3 is only used here.
        multiplier_rows[w.row] = carried;
        if (w.row == LAST_ROW) begin
          for (i = 0; i < DIM; i++) begin
            for (k = 0; k < DIM; k++) begin
              sum = '0;
              for (j = 0; j < DIM; j++) begin
                a = multiplier_rows[i][j];
                b = accum_rows[j][k];
                sum += a * b;
              end
              // Arithmetic shift gives the floor of the Q32.32 sum.
              sum = sum >>> FRAC_W;
              if (sum > SUM_MAX) begin
                prod[i][k] = Q_MAX;
                clipped = 1'b1;
              end else if (sum < SUM_MIN) begin
                prod[i][k] = Q_MIN;
                clipped = 1'b1;
              end else begin
                prod[i][k] = elem_t'(sum[ELEM_W-1:0]);
              end
            end
          end
          accum_rows = prod;
        end
      end
      CMD_RESTORE: begin
        accum_rows = base_rows;
      end
      default: begin
      end
    endcase
    o.out_row = w.row;
    o.acc_0 = accum_rows[w.row][0];
    o.acc_1 = accum_rows[w.row][1];
    o.acc_2 = accum_rows[w.row][2];
    o.acc_3 = accum_rows[w.row][3];
    o.product_done = (w.cmd == CMD_APPLY) && (w.row == LAST_ROW);
    o.saturated = clipped;
    return o;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_word_t want;
    int        i;
    int        j;
    if (rst) begin
      for (i = 0; i < DIM; i++) begin
        for (j = 0; j < DIM; j++) begin
          base_rows[i][j] = (i == j) ? Q_ONE : Q_ZERO;
          accum_rows[i][j] = (i == j) ? Q_ONE : Q_ZERO;
          multiplier_rows[i][j] = Q_ZERO;
        end
      end
      expected_rows.delete();
      mismatch_count = 0;
    end else begin
      // The word leaving now belongs to an earlier item, so compare before queuing.
      if (done) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: result word with no expectation, actual %h", $time, result);
          mismatch_count++;
        end else begin
          want = expected_rows.pop_front();
          compare_field("out_row", 32'(want.out_row), 32'(result.out_row));
          compare_field("acc_0", want.acc_0, result.acc_0);
          compare_field("acc_1", want.acc_1, result.acc_1);
          compare_field("acc_2", want.acc_2, result.acc_2);
          compare_field("acc_3", want.acc_3, result.acc_3);
          compare_field("product_done", 32'(want.product_done), 32'(result.product_done));
          compare_field("saturated", 32'(want.saturated), 32'(result.saturated));
        end
      end
      if (start && !busy) begin
        expected_rows = {expected_rows, transform_step(item)};
      end
    end
    words_in_flight = expected_rows.size();
  end

endmodule

/* test/tb_transform_matrix_accumulator_unit.sv */
// Testbench top for the transform matrix accumulator unit: drives directed and
// random command words and gives the verdict. Depends on tmau_pkg, the DUT and
// tmau_checker, which does all prediction and comparison.
module tb_transform_matrix_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tmau_pkg::*;

  localparam int N_ITEMS = 2000;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 25;
  localparam elem_t Q_NEG_ONE = -Q_ONE;

  logic      clk;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  logic      done;
  in_word_t  item = '0;
  out_word_t result;
  int        mismatches;
  int        in_flight;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  logic [2:0] mult_row_loaded = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  transform_matrix_accumulator_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  tmau_checker acc_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .done            (done),
    .result          (result),
    .mismatch_count  (mismatches),
    .words_in_flight (in_flight)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t make_word(cmd_t c, row_t r, elem_t e0, elem_t e1,
                                         elem_t e2, elem_t e3);
    in_word_t w;
    w.cmd = c;
    w.row = r;
    w.elem_0 = e0;
    w.elem_1 = e1;
    w.elem_2 = e2;
    w.elem_3 = e3;
    return w;
  endfunction

  // Mostly modest Q16.16 values so products stay in range, with some full-range
  // and extreme values to drive saturation.
  function automatic elem_t rand_elem();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 262143)) - 131072;
      4, 5: v = ($urandom_range(0, 1) ? 65536 : -65536) + int'($urandom_range(0, 8191)) - 4096;
      6: v = int'($urandom());
      7: begin
        case ($urandom_range(0, 5))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = Q_ZERO;
          3: v = -1;
          4: v = Q_ONE;
          default: v = Q_NEG_ONE;
        endcase
      end
      8: v = int'($urandom_range(0, 65535)) * ($urandom_range(0, 1) ? 1 : -1);
      default: v = 0;
    endcase
    return elem_t'(v);
  endfunction

  function automatic in_word_t rand_word(cmd_t c, row_t r);
    return make_word(c, r, rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endfunction

  // Presents one word from a falling edge and returns after the edge that takes it.
  task automatic send(in_word_t w);
    int gap;
    gap = 0;
    if ((items_sent < 800 || items_sent >= 1200) && $urandom_range(0, 99) < 24) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
    end
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (w.cmd == CMD_APPLY && w.row != LAST_ROW) begin
      mult_row_loaded[w.row] = 1'b1;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int pick;
    int first;
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity after reset, then an identity product.
    send(make_word(CMD_READ, 2'd0, elem_t'(32'hA5A5_5A5A), Q_MAX, Q_MIN, elem_t'(-1)));
    send(make_word(CMD_APPLY, 2'd0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    send(make_word(CMD_APPLY, 2'd1, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
    send(make_word(CMD_APPLY, 2'd2, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
    send(make_word(CMD_APPLY, LAST_ROW, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE));
    // Extreme base rows, then a product on them that reuses the collected rows.
    send(make_word(CMD_LOAD, 2'd0, Q_MAX, Q_MIN, Q_ZERO, elem_t'(-1)));
    send(make_word(CMD_LOAD, 2'd1, Q_MIN, Q_MAX, Q_ONE, Q_NEG_ONE));
    send(make_word(CMD_LOAD, 2'd2, elem_t'(32'h5555_5555), elem_t'(32'hAAAA_AAAA),
                   elem_t'(1), Q_MAX));
    send(make_word(CMD_LOAD, LAST_ROW, elem_t'(-1), Q_MIN, Q_MAX, Q_ZERO));
    send(make_word(CMD_APPLY, LAST_ROW, Q_MAX, Q_MIN, Q_ONE, elem_t'(-1)));
    send(make_word(CMD_RESTORE, 2'd2, elem_t'(-1), elem_t'(-1), elem_t'(-1), elem_t'(-1)));
    // Large multiplier rows clip both ways.
    send(make_word(CMD_APPLY, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send(make_word(CMD_APPLY, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send(make_word(CMD_APPLY, 2'd2, elem_t'(-1), elem_t'(1), Q_ONE, Q_NEG_ONE));
    send(make_word(CMD_APPLY, LAST_ROW, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    send(make_word(CMD_RESTORE, 2'd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    send(make_word(CMD_READ, LAST_ROW, elem_t'(-1), elem_t'(-1), elem_t'(-1), elem_t'(-1)));
    // Tiny negative terms check that the shift rounds toward minus infinity.
    send(make_word(CMD_APPLY, LAST_ROW, elem_t'(-1), elem_t'(-1), elem_t'(-1), elem_t'(-1)));
    send(make_word(CMD_LOAD, 2'd0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    send(make_word(CMD_LOAD, 2'd1, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
    send(make_word(CMD_LOAD, 2'd2, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
    send(make_word(CMD_LOAD, LAST_ROW, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE));
    send(make_word(CMD_READ, 2'd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    drain();

    while (items_sent < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        first = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) begin
          send(rand_word(CMD_APPLY, row_t'((first + k) % 3)));
        end
        send(rand_word(CMD_APPLY, LAST_ROW));
      end else if (pick < 58 && &mult_row_loaded) begin
        send(rand_word(CMD_APPLY, LAST_ROW));
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 4)) send(rand_word(CMD_LOAD, row_t'($urandom_range(0, 3))));
      end else if (pick < 80) begin
        send(rand_word(CMD_RESTORE, row_t'($urandom_range(0, 3))));
      end else if (pick < 93) begin
        send(rand_word(CMD_READ, row_t'($urandom_range(0, 3))));
      end else begin
        // An abandoned multiplier: some rows collected and no closing row.
        repeat ($urandom_range(1, 2)) send(rand_word(CMD_APPLY, row_t'($urandom_range(0, 2))));
      end
      if ($urandom_range(0, 299) == 0) begin
        drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tmau_pkg.sv
hdl/transform_matrix_accumulator_unit.sv
test/tmau_checker.sv
test/tb_transform_matrix_accumulator_unit.sv
